>>> rtl/sei_pkg.sv
// ----------------------------------------------------------------------------
// sei_pkg
// Shared constants, types and helpers of the subgraph edge index enumerator.
// ----------------------------------------------------------------------------
package sei_pkg;

    localparam int NUM_VERTICES = 16;
    localparam int NUM_EDGES    = 120;
    localparam int MAX_SUBSET   = 8;

    // Widths that follow from the constants above.
    localparam int VERT_W = $clog2(NUM_VERTICES + 1);
    localparam int IDX_W  = $clog2(MAX_SUBSET);
    localparam int PROD_W = 2 * VERT_W;
    localparam int EDGE_W = $clog2(NUM_EDGES);

    // Fixed field widths of the streams and the size register.
    localparam int SIZE_W  = 4;
    localparam int LABEL_W = 14;
    localparam int SLOT_W  = 12;
    localparam int POS_W   = 5;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 40;

    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(4);
    localparam logic [SIZE_W-1:0] SIZE_MIN   = SIZE_W'(2);

    // Output queue.
    localparam int OUTQ_DEPTH = 4;
    localparam int OUTQ_PTR_W = $clog2(OUTQ_DEPTH);
    localparam int OUTQ_CNT_W = $clog2(OUTQ_DEPTH + 1);

    // One vertex pair on its way to the fill counter memory.
    typedef struct packed {
        logic [LABEL_W-1:0] label;
        logic [EDGE_W-1:0]  edge_idx;
        logic               in_range;
        logic [POS_W-1:0]   pos;
        logic               last;
        logic               done;
    } pair_t;

    // One finished result.
    typedef struct packed {
        logic [LABEL_W-1:0] label;
        logic [EDGE_W-1:0]  edge_idx;
        logic [SLOT_W-1:0]  slot;
        logic [POS_W-1:0]   pos;
        logic               last;
        logic               done;
    } result_t;

    // Size in use: the register value clamped into 2..MAX_SUBSET.
    function automatic logic [SIZE_W-1:0] sat_size(input logic [SIZE_W-1:0] raw);
        logic [SIZE_W-1:0] t;
        t = raw;
        if (raw < SIZE_MIN)
            t = SIZE_MIN;
        else if (int'(raw) > MAX_SUBSET)
            t = SIZE_W'(MAX_SUBSET);
        return t;
    endfunction

    // A subset larger than the vertex set has nothing to walk.
    function automatic logic too_big(input logic [SIZE_W-1:0] t);
        return int'(t) > NUM_VERTICES;
    endfunction

endpackage

>>> rtl/sei_req_fifo.sv
// ----------------------------------------------------------------------------
// sei_req_fifo
// Front end: takes request transfers and queues their restart flags.
// ----------------------------------------------------------------------------
module sei_req_fifo
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [sei_pkg::IN_TDATA_W-1:0]    s_tdata,
    output logic                              req_valid,
    output logic                              req_restart,
    input  logic                              req_pop
);

    logic [1:0] flag_reg;
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push;
    logic       pop;

    assign s_tready    = (count_reg != 2'd2);
    assign push        = s_tvalid && s_tready;
    assign req_valid   = (count_reg != 2'd0);
    assign req_restart = flag_reg[rd_ptr_reg];
    assign pop         = req_pop && req_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flag_reg   <= 2'b00;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                flag_reg[wr_ptr_reg] <= s_tdata[0];
                wr_ptr_reg           <= ~wr_ptr_reg;
            end
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            if (push && !pop)
                count_reg <= count_reg + 2'd1;
            else if (pop && !push)
                count_reg <= count_reg - 2'd1;
        end
    end

endmodule

>>> rtl/sei_walker.sv
// ----------------------------------------------------------------------------
// sei_walker
// Back end sequencer: holds the current subset, issues its vertex pairs one
// per cycle while room is set, and steps to the next subset in colex order.
// ----------------------------------------------------------------------------
module sei_walker
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [sei_pkg::SIZE_W-1:0]     cfg_wdata,
    input  logic                           req_valid,
    input  logic                           req_restart,
    output logic                           req_pop,
    input  logic                           room,
    output logic                           clear,
    output logic                           pair_valid,
    output sei_pkg::pair_t                 pair
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_START,
        ST_GEN,
        ST_ADV
    } state_t;

    state_t                              state_reg;
    logic [sei_pkg::SIZE_W-1:0]          size_reg;
    logic [sei_pkg::VERT_W-1:0]          c_reg    [sei_pkg::MAX_SUBSET];
    logic [sei_pkg::VERT_W-1:0]          jvec_reg [sei_pkg::MAX_SUBSET];
    logic [sei_pkg::VERT_W-1:0]          kvec_reg [sei_pkg::MAX_SUBSET];
    logic [sei_pkg::IDX_W-1:0]           k_reg;
    logic [sei_pkg::IDX_W-1:0]           j_reg;
    logic [sei_pkg::POS_W-1:0]           n_reg;
    logic [sei_pkg::LABEL_W-1:0]         counter_reg;
    logic                                finished_reg;
    logic                                final_reg;

    logic [sei_pkg::SIZE_W-1:0]          t_use;
    logic [sei_pkg::VERT_W-1:0]          shifted  [sei_pkg::MAX_SUBSET];
    logic [sei_pkg::VERT_W-1:0]          above    [sei_pkg::MAX_SUBSET];
    logic [sei_pkg::VERT_W-1:0]          c_adv    [sei_pkg::MAX_SUBSET];
    logic [sei_pkg::MAX_SUBSET-1:0]      fail;
    logic [sei_pkg::SIZE_W-1:0]          fail_pos;
    logic                                is_final;

    logic [sei_pkg::VERT_W-1:0]          cj;
    logic [sei_pkg::VERT_W-1:0]          ck;
    logic [sei_pkg::VERT_W-1:0]          ck_m1;
    logic [sei_pkg::PROD_W-1:0]          prod;
    logic [sei_pkg::PROD_W-1:0]          ei;
    logic                                j_end;
    logic                                pair_last;

    assign t_use = sei_pkg::sat_size(size_reg);

    // Successor of the current subset and the test for the final one.
    always_comb
    begin
        for (int i = 0; i < sei_pkg::MAX_SUBSET - 1; i++)
            shifted[i] = c_reg[i + 1];
        shifted[sei_pkg::MAX_SUBSET - 1] = sei_pkg::VERT_W'(sei_pkg::NUM_VERTICES);

        for (int i = 0; i < sei_pkg::MAX_SUBSET; i++)
        begin
            if (i + 1 < int'(t_use))
                above[i] = shifted[i];
            else
                above[i] = sei_pkg::VERT_W'(sei_pkg::NUM_VERTICES);
            fail[i] = (i < int'(t_use)) &&
                      (({1'b0, c_reg[i]} + 1'b1) != {1'b0, above[i]});
        end
        is_final = ~|fail;

        fail_pos = t_use;
        for (int i = sei_pkg::MAX_SUBSET - 1; i >= 0; i--)
        begin
            if (fail[i])
                fail_pos = sei_pkg::SIZE_W'(i);
        end

        for (int i = 0; i < sei_pkg::MAX_SUBSET; i++)
        begin
            if (i < int'(fail_pos))
                c_adv[i] = sei_pkg::VERT_W'(i);
            else if (i == int'(fail_pos) && !is_final)
                c_adv[i] = c_reg[i] + 1'b1;
            else
                c_adv[i] = c_reg[i];
        end
    end

    // Triangular edge index of the pair at the head of the two shift lines.
    always_comb
    begin
        cj    = jvec_reg[0];
        ck    = kvec_reg[0];
        ck_m1 = ck - 1'b1;
        prod  = ck * ck_m1;
        ei    = {1'b0, prod[sei_pkg::PROD_W-1:1]} + sei_pkg::PROD_W'(cj);
    end

    assign j_end     = (j_reg == k_reg - 1'b1);
    assign pair_last = j_end && ({1'b0, k_reg} == t_use - 1'b1);

    assign pair_valid     = (state_reg == ST_GEN) && room;
    assign pair.label     = counter_reg;
    assign pair.edge_idx  = ei[sei_pkg::EDGE_W-1:0];
    assign pair.in_range  = (ei < sei_pkg::PROD_W'(sei_pkg::NUM_EDGES));
    assign pair.pos       = n_reg;
    assign pair.last      = pair_last;
    assign pair.done      = final_reg;

    assign req_pop = (state_reg == ST_IDLE) && req_valid;
    assign clear   = cfg_we || (req_pop && req_restart);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            size_reg     <= sei_pkg::SIZE_RESET;
            counter_reg  <= '0;
            finished_reg <= sei_pkg::too_big(sei_pkg::sat_size(sei_pkg::SIZE_RESET));
            final_reg    <= 1'b0;
            k_reg        <= '0;
            j_reg        <= '0;
            n_reg        <= '0;
            for (int i = 0; i < sei_pkg::MAX_SUBSET; i++)
            begin
                c_reg[i]    <= sei_pkg::VERT_W'(i);
                jvec_reg[i] <= '0;
                kvec_reg[i] <= '0;
            end
        end
        else if (cfg_we)
        begin
            // A size write restarts the walk without emitting anything.
            state_reg    <= ST_IDLE;
            size_reg     <= cfg_wdata;
            counter_reg  <= '0;
            finished_reg <= sei_pkg::too_big(sei_pkg::sat_size(cfg_wdata));
            for (int i = 0; i < sei_pkg::MAX_SUBSET; i++)
                c_reg[i] <= sei_pkg::VERT_W'(i);
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (req_valid)
                    begin
                        if (req_restart)
                        begin
                            counter_reg  <= '0;
                            finished_reg <= sei_pkg::too_big(t_use);
                            for (int i = 0; i < sei_pkg::MAX_SUBSET; i++)
                                c_reg[i] <= sei_pkg::VERT_W'(i);
                        end
                        state_reg <= ST_START;
                    end
                end
                ST_START:
                begin
                    if (finished_reg)
                        state_reg <= ST_IDLE;
                    else
                    begin
                        final_reg <= is_final;
                        k_reg     <= sei_pkg::IDX_W'(1);
                        j_reg     <= '0;
                        n_reg     <= '0;
                        for (int i = 0; i < sei_pkg::MAX_SUBSET; i++)
                        begin
                            jvec_reg[i] <= c_reg[i];
                            kvec_reg[i] <= shifted[i];
                        end
                        state_reg <= ST_GEN;
                    end
                end
                ST_GEN:
                begin
                    if (room)
                    begin
                        n_reg <= n_reg + 1'b1;
                        if (pair_last)
                            state_reg <= ST_ADV;
                        else if (j_end)
                        begin
                            k_reg <= k_reg + 1'b1;
                            j_reg <= '0;
                            for (int i = 0; i < sei_pkg::MAX_SUBSET; i++)
                                jvec_reg[i] <= c_reg[i];
                            for (int i = 0; i < sei_pkg::MAX_SUBSET - 1; i++)
                                kvec_reg[i] <= kvec_reg[i + 1];
                        end
                        else
                        begin
                            j_reg <= j_reg + 1'b1;
                            for (int i = 0; i < sei_pkg::MAX_SUBSET - 1; i++)
                                jvec_reg[i] <= jvec_reg[i + 1];
                        end
                    end
                end
                ST_ADV:
                begin
                    counter_reg <= counter_reg + 1'b1;
                    if (is_final)
                        finished_reg <= 1'b1;
                    for (int i = 0; i < sei_pkg::MAX_SUBSET; i++)
                        c_reg[i] <= c_adv[i];
                    state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

>>> rtl/sei_edge_counts.sv
// ----------------------------------------------------------------------------
// sei_edge_counts
// Per-edge fill counters: a read-modify-write memory with one valid bit per
// edge, so that a restart clears every counter by resetting the valid bits.
// ----------------------------------------------------------------------------
module sei_edge_counts
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 clear,
    input  logic                 pair_valid,
    input  sei_pkg::pair_t       pair,
    output logic                 res_valid,
    output sei_pkg::result_t     res
);

    logic [sei_pkg::SLOT_W-1:0]    mem [sei_pkg::NUM_EDGES];
    logic [sei_pkg::NUM_EDGES-1:0] vld_reg;

    logic                          s2_valid_reg;
    sei_pkg::pair_t                s2_pair_reg;
    logic [sei_pkg::SLOT_W-1:0]    rd_data_reg;
    logic                          hit_reg;
    logic                          byp_hit_reg;
    logic [sei_pkg::SLOT_W-1:0]    byp_data_reg;

    logic                          rd_en;
    logic                          wr_en;
    logic [sei_pkg::SLOT_W-1:0]    slot;
    logic [sei_pkg::SLOT_W-1:0]    wr_data;

    assign rd_en = pair_valid && pair.in_range;

    // A counter that was never written since the last clear reads as zero;
    // a write in the cycle of the read is forwarded.
    always_comb
    begin
        if (!s2_pair_reg.in_range)
            slot = '0;
        else if (byp_hit_reg)
            slot = byp_data_reg;
        else if (hit_reg)
            slot = rd_data_reg;
        else
            slot = '0;
    end

    assign wr_en   = s2_valid_reg && s2_pair_reg.in_range;
    assign wr_data = slot + 1'b1;

    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_data_reg <= mem[pair.edge_idx];
        if (wr_en)
            mem[s2_pair_reg.edge_idx] <= wr_data;
        if (pair_valid)
            s2_pair_reg <= pair;
        byp_data_reg <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg      <= '0;
            s2_valid_reg <= 1'b0;
            hit_reg      <= 1'b0;
            byp_hit_reg  <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= pair_valid;
            if (pair_valid)
            begin
                hit_reg     <= rd_en && vld_reg[pair.edge_idx];
                byp_hit_reg <= wr_en && (s2_pair_reg.edge_idx == pair.edge_idx);
            end
            if (clear)
                vld_reg <= '0;
            else if (wr_en)
                vld_reg[s2_pair_reg.edge_idx] <= 1'b1;
        end
    end

    assign res_valid    = s2_valid_reg;
    assign res.label    = s2_pair_reg.label;
    assign res.edge_idx = s2_pair_reg.edge_idx;
    assign res.slot     = slot;
    assign res.pos      = s2_pair_reg.pos;
    assign res.last     = s2_pair_reg.last;
    assign res.done     = s2_pair_reg.done;

endmodule

>>> rtl/sei_out_fifo.sv
// ----------------------------------------------------------------------------
// sei_out_fifo
// Result queue toward the output stream; grants issue credit to the walker.
// ----------------------------------------------------------------------------
module sei_out_fifo
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  sei_pkg::result_t     push_data,
    input  logic                 pend,
    output logic                 room,
    output logic                 out_valid,
    input  logic                 out_ready,
    output sei_pkg::result_t     out_data
);

    sei_pkg::result_t                 entry_reg [sei_pkg::OUTQ_DEPTH];
    logic [sei_pkg::OUTQ_PTR_W-1:0]   wr_ptr_reg;
    logic [sei_pkg::OUTQ_PTR_W-1:0]   rd_ptr_reg;
    logic [sei_pkg::OUTQ_CNT_W-1:0]   count_reg;
    logic                             pop;

    // A pair in the memory stage already owns a place in the queue.
    assign room = (int'(count_reg) + int'(pend)) < sei_pkg::OUTQ_DEPTH;

    assign out_valid = (count_reg != '0);
    assign out_data  = entry_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

>>> rtl/subgraph_edge_index_enumerator.sv
// ----------------------------------------------------------------------------
// subgraph_edge_index_enumerator: vertex-pair edge indexes of t-vertex subsets
// A request passes the request queue, the walker, the fill counter stage and the
// result queue; its results leave one per cycle while the output stream is ready,
// and the walker takes no new request until it has stepped to the next subset.
// Reset (rst_n, async, low) restores size 4, the first subset and clear counters.
// ----------------------------------------------------------------------------
module subgraph_edge_index_enumerator
(
    input  logic                               clk,
    input  logic                               rst_n,
    // Size register: number of vertices per subset.
    input  logic                               cfg_we,
    input  logic [sei_pkg::SIZE_W-1:0]         cfg_wdata,
    // Request stream.
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [sei_pkg::IN_TDATA_W-1:0]     s_tdata,   // [0] restart, [7:1] zero
    // Result stream.
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [13:0] subgraph_label, [20:14] edge_index, [32:21] slot_in_edge_list,
    // [37:33] slot_in_subgraph_list, [39:38] zero
    output logic [sei_pkg::OUT_TDATA_W-1:0]    m_tdata,
    output logic                               m_tlast,   // last_of_subgraph
    output logic                               m_tuser    // enumeration_done
);

    // The front end queues requests, the walker turns each one into the pairs
    // of the current subset, the fill counter stage attaches each edge's slot,
    // and the result queue decouples all of this from the output stream. The
    // walker only issues a pair when the result queue is sure to take it, so
    // the memory stage never stalls.

    logic                 req_valid;
    logic                 req_restart;
    logic                 req_pop;
    logic                 room;
    logic                 clear;
    logic                 pair_valid;
    sei_pkg::pair_t       pair;
    logic                 res_valid;
    sei_pkg::result_t     res;
    sei_pkg::result_t     out_data;

    sei_req_fifo u_req_fifo
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .req_valid   (req_valid),
        .req_restart (req_restart),
        .req_pop     (req_pop)
    );

    // The walker also holds the size register; a write restarts the walk and
    // clears the fill counters, just as a restart request does.
    sei_walker u_walker
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .req_valid   (req_valid),
        .req_restart (req_restart),
        .req_pop     (req_pop),
        .room        (room),
        .clear       (clear),
        .pair_valid  (pair_valid),
        .pair        (pair)
    );

    sei_edge_counts u_edge_counts
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .clear       (clear),
        .pair_valid  (pair_valid),
        .pair        (pair),
        .res_valid   (res_valid),
        .res         (res)
    );

    sei_out_fifo u_out_fifo
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (res_valid),
        .push_data   (res),
        .pend        (res_valid),
        .room        (room),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_data    (out_data)
    );

    // Pack one result per output transfer, first field in the lowest bits.
    assign m_tdata = {2'b00, out_data.pos, out_data.slot, out_data.edge_idx,
                      out_data.label};
    assign m_tlast = out_data.last;
    assign m_tuser = out_data.done;

endmodule
